// ===== sv/chbs_pkg.sv =====
// Package for the comment high-byte scrubber.
// Holds the lexical mode codes, the character constants and the step result type.
// No dependencies.
package chbs_pkg;

  // Lexical context of the byte stream.
  typedef enum logic [3:0] {
    MODE_CODE       = 4'd0,
    MODE_SQ         = 4'd1,
    MODE_DQ         = 4'd2,
    MODE_SQ_ESC     = 4'd3,
    MODE_DQ_ESC     = 4'd4,
    MODE_LINE       = 4'd5,
    MODE_BLOCK      = 4'd6,
    MODE_CODE_SLASH = 4'd7,
    MODE_BLOCK_STAR = 4'd8
  } lex_mode_t;

  localparam logic [7:0] HIGH_BYTE  = 8'h80;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  // What one byte does to the lexer: the following mode and the replace decision.
  typedef struct packed {
    lex_mode_t mode;
    logic      replace;
  } step_t;

endpackage

// ===== sv/chbs_if.sv =====
// Stream interfaces for the comment high-byte scrubber.
// One for input beats, one for result beats; valid/ready handshake.
// No dependencies.
interface chbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_final;

  modport source (output valid, output text_byte, output is_final, input ready);
  modport sink (input valid, input text_byte, input is_final, output ready);
endinterface

interface chbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] clean_byte;
  logic       was_replaced;
  logic       any_changed;
  logic       end_mark;

  modport source (output valid, output clean_byte, output was_replaced,
                  output any_changed, output end_mark, input ready);
  modport sink (input valid, input clean_byte, input was_replaced,
                input any_changed, input end_mark, output ready);
endinterface

// ===== sv/chbs_lex_step.sv =====
// Lexer transition logic for the comment high-byte scrubber.
// Maps the current mode and one byte to the next mode and the replace flag.
// Depends on chbs_pkg.
module chbs_lex_step (
  input  chbs_pkg::lex_mode_t mode,
  input  logic [7:0]          text_byte,
  output chbs_pkg::step_t     step
);

  logic      is_high;
  chbs_pkg::lex_mode_t code_mode;

  assign is_high = (text_byte >= chbs_pkg::HIGH_BYTE);

  // Mode that a byte in plain code leads to.
  always_comb begin
    if (text_byte == chbs_pkg::CH_SLASH) begin
      code_mode = chbs_pkg::MODE_CODE_SLASH;
    end else if (text_byte == chbs_pkg::CH_SQUOTE) begin
      code_mode = chbs_pkg::MODE_SQ;
    end else if (text_byte == chbs_pkg::CH_DQUOTE) begin
      code_mode = chbs_pkg::MODE_DQ;
    end else begin
      code_mode = chbs_pkg::MODE_CODE;
    end
  end

  // Transition table; unused codes behave as plain code.
  always_comb begin
    step.mode    = mode;
    step.replace = 1'b0;
    unique case (mode)
      chbs_pkg::MODE_CODE_SLASH: begin
        if (text_byte == chbs_pkg::CH_SLASH) begin
          step.mode = chbs_pkg::MODE_LINE;
        end else if (text_byte == chbs_pkg::CH_STAR) begin
          step.mode = chbs_pkg::MODE_BLOCK;
        end else begin
          step.mode = code_mode;
        end
      end
      chbs_pkg::MODE_SQ: begin
        if (text_byte == chbs_pkg::CH_BSLASH) begin
          step.mode = chbs_pkg::MODE_SQ_ESC;
        end else if (text_byte == chbs_pkg::CH_SQUOTE) begin
          step.mode = chbs_pkg::MODE_CODE;
        end
      end
      chbs_pkg::MODE_DQ: begin
        if (text_byte == chbs_pkg::CH_BSLASH) begin
          step.mode = chbs_pkg::MODE_DQ_ESC;
        end else if (text_byte == chbs_pkg::CH_DQUOTE) begin
          step.mode = chbs_pkg::MODE_CODE;
        end
      end
      chbs_pkg::MODE_SQ_ESC: step.mode = chbs_pkg::MODE_SQ;
      chbs_pkg::MODE_DQ_ESC: step.mode = chbs_pkg::MODE_DQ;
      chbs_pkg::MODE_LINE: begin
        if (text_byte == chbs_pkg::CH_CR || text_byte == chbs_pkg::CH_LF) begin
          step.mode = chbs_pkg::MODE_CODE;
        end else begin
          step.replace = is_high;
        end
      end
      chbs_pkg::MODE_BLOCK: begin
        if (text_byte == chbs_pkg::CH_STAR) begin
          step.mode = chbs_pkg::MODE_BLOCK_STAR;
        end else begin
          step.replace = is_high;
        end
      end
      chbs_pkg::MODE_BLOCK_STAR: begin
        if (text_byte == chbs_pkg::CH_SLASH) begin
          step.mode = chbs_pkg::MODE_CODE;
        end else if (text_byte != chbs_pkg::CH_STAR) begin
          step.mode    = chbs_pkg::MODE_BLOCK;
          step.replace = is_high;
        end
      end
      default: step.mode = code_mode;
    endcase
  end

endmodule

// ===== sv/comment_high_byte_scrubber_top.sv =====
// Top level of the comment high-byte scrubber.
// Depends on chbs_pkg, chbs_in_if, chbs_out_if and chbs_lex_step.
//
// The block takes one source-text byte per beat and returns one result beat per
// byte in the cycle after it is taken, at a sustained rate of one byte per cycle
// while the receiver is ready; the only loop is the lexer mode register, fed by
// the transition logic. It follows code, quoted literals with backslash escapes,
// line comments and block comments, and turns any byte of 0x80 or above inside
// a comment into a space. A byte marked final returns the lexer and the sticky
// changed flag to their reset values. A single output register decouples the
// sides: a new byte is taken whenever that register is empty or being drained.
module comment_high_byte_scrubber_top (
  input logic            clk,
  input logic            rst,
  chbs_in_if.sink        in_ch,
  chbs_out_if.source     out_ch
);

  chbs_pkg::lex_mode_t mode;
  logic                changed;
  logic                changed_next;
  chbs_pkg::step_t     step;
  logic                in_fire;

  logic                out_valid;
  logic [7:0]          clean_byte;
  logic                was_replaced;
  logic                any_changed;
  logic                end_mark;

  chbs_lex_step u_step (
    .mode      (mode),
    .text_byte (in_ch.text_byte),
    .step      (step)
  );

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign changed_next = changed || step.replace;

  // Lexer context and sticky flag; a final beat closes the buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= chbs_pkg::MODE_CODE;
      changed <= 1'b0;
    end else if (in_fire) begin
      if (in_ch.is_final) begin
        mode    <= chbs_pkg::MODE_CODE;
        changed <= 1'b0;
      end else begin
        mode    <= step.mode;
        changed <= changed_next;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      clean_byte   <= step.replace ? chbs_pkg::SPACE_BYTE : in_ch.text_byte;
      was_replaced <= step.replace;
      any_changed  <= changed_next;
      end_mark     <= in_ch.is_final;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.clean_byte   = clean_byte;
  assign out_ch.was_replaced = was_replaced;
  assign out_ch.any_changed  = any_changed;
  assign out_ch.end_mark     = end_mark;

  // A replaced byte always reads as a space and sets the sticky flag.
  a_replaced_space: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_replaced |-> clean_byte == chbs_pkg::SPACE_BYTE && any_changed)
    else $error("replaced byte not a space or sticky flag clear");

  // A final beat leaves the lexer in plain code with the flag clear.
  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.is_final |=> mode == chbs_pkg::MODE_CODE && !changed)
    else $error("context not reset after final beat");

  // An empty output register never stalls the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input stalled with empty output register");

  // Every accepted beat produces a result in the next cycle.
  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid && end_mark == $past(in_ch.is_final))
    else $error("accepted beat did not reach output register");

  // Sticky flag only rises on a replaced byte.
  a_sticky_source: assert property (@(posedge clk) disable iff (rst)
    $rose(changed) |-> $past(in_fire && step.replace))
    else $error("sticky flag set without a replaced byte");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for comment_high_byte_scrubber_top.
// Depends on chbs_pkg, chbs_in_if, chbs_out_if and the scrubber RTL; drives
// directed and randomized source text and checks every result beat in order.
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 80;
  localparam int PHASE_BYTES    = 267;

  // One expected result beat.
  typedef struct {
    logic [7:0] clean_byte;
    logic       was_replaced;
    logic       any_changed;
    logic       end_mark;
  } scrub_result_t;

  // Tracks the lexer context of the stream and holds the results still due.
  class scrub_scoreboard;
    chbs_pkg::lex_mode_t mode;
    bit                  changed;
    scrub_result_t       due_q[$];
    int                  errors;

    function new();
      mode    = chbs_pkg::MODE_CODE;
      changed = 1'b0;
      errors  = 0;
    endfunction

    // Context that a byte opens from plain code.
    function chbs_pkg::lex_mode_t after_code(logic [7:0] b);
      if (b == chbs_pkg::CH_SLASH) return chbs_pkg::MODE_CODE_SLASH;
      if (b == chbs_pkg::CH_SQUOTE) return chbs_pkg::MODE_SQ;
      if (b == chbs_pkg::CH_DQUOTE) return chbs_pkg::MODE_DQ;
      return chbs_pkg::MODE_CODE;
    endfunction

    // Works out the result of one accepted byte and advances the context.
    function void note_byte(logic [7:0] b, logic fin);
      chbs_pkg::lex_mode_t nxt;
      bit                  rep;
      scrub_result_t       r;
      nxt = mode;
      rep = 1'b0;
      case (mode)
        chbs_pkg::MODE_CODE_SLASH: begin
          if (b == chbs_pkg::CH_SLASH) nxt = chbs_pkg::MODE_LINE;
          else if (b == chbs_pkg::CH_STAR) nxt = chbs_pkg::MODE_BLOCK;
          else nxt = after_code(b);
        end
        chbs_pkg::MODE_SQ: begin
          if (b == chbs_pkg::CH_BSLASH) nxt = chbs_pkg::MODE_SQ_ESC;
          else if (b == chbs_pkg::CH_SQUOTE) nxt = chbs_pkg::MODE_CODE;
        end
        chbs_pkg::MODE_DQ: begin
          if (b == chbs_pkg::CH_BSLASH) nxt = chbs_pkg::MODE_DQ_ESC;
          else if (b == chbs_pkg::CH_DQUOTE) nxt = chbs_pkg::MODE_CODE;
        end
        chbs_pkg::MODE_SQ_ESC: nxt = chbs_pkg::MODE_SQ;
        chbs_pkg::MODE_DQ_ESC: nxt = chbs_pkg::MODE_DQ;
        chbs_pkg::MODE_LINE: begin
          if (b == chbs_pkg::CH_CR || b == chbs_pkg::CH_LF) nxt = chbs_pkg::MODE_CODE;
          else if (b >= chbs_pkg::HIGH_BYTE) rep = 1'b1;
        end
        chbs_pkg::MODE_BLOCK: begin
          if (b == chbs_pkg::CH_STAR) nxt = chbs_pkg::MODE_BLOCK_STAR;
          else if (b >= chbs_pkg::HIGH_BYTE) rep = 1'b1;
        end
        chbs_pkg::MODE_BLOCK_STAR: begin
          if (b == chbs_pkg::CH_SLASH) begin
            nxt = chbs_pkg::MODE_CODE;
          end else if (b == chbs_pkg::CH_STAR) begin
            nxt = chbs_pkg::MODE_BLOCK_STAR;
          end else begin
            rep = (b >= chbs_pkg::HIGH_BYTE);
            nxt = chbs_pkg::MODE_BLOCK;
          end
        end
        default: nxt = after_code(b);
      endcase

      if (rep) changed = 1'b1;
      r.clean_byte   = rep ? chbs_pkg::SPACE_BYTE : b;
      r.was_replaced = rep;
      r.any_changed  = changed;
      r.end_mark     = fin;
      due_q.push_back(r);

      // The last byte of a buffer returns the lexer to its reset context.
      if (fin) begin
        mode    = chbs_pkg::MODE_CODE;
        changed = 1'b0;
      end else begin
        mode = nxt;
      end
    endfunction

    function void compare_field(string field, logic [7:0] exp, logic [7:0] act);
      if (exp !== act) begin
        errors++;
        $display("%0t ns: %s expected %h, got %h", $time, field, exp, act);
      end
    endfunction

    // Compares one result beat with the oldest one still due.
    function void check_result(logic [7:0] cb, logic rep, logic chg, logic em);
      scrub_result_t r;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result beat, expected none, got byte %h", $time, cb);
        return;
      end
      r = due_q.pop_front();
      compare_field("clean_byte", r.clean_byte, cb);
      compare_field("was_replaced", {7'd0, r.was_replaced}, {7'd0, rep});
      compare_field("any_changed", {7'd0, r.any_changed}, {7'd0, chg});
      compare_field("end_mark", {7'd0, r.end_mark}, {7'd0, em});
    endfunction
  endclass

  logic clk;
  logic rst;

  chbs_in_if  in_ch();
  chbs_out_if out_ch();

  comment_high_byte_scrubber_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scrub_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  bit              hold_request;
  int              quiet_cycles;
  logic [7:0]      text_q[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Beat monitor and watchdog, both sampled at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_byte(in_ch.text_byte, in_ch.is_final);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.clean_byte, out_ch.was_replaced,
                        out_ch.any_changed, out_ch.end_mark);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one byte, with random gaps before it, and waits until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid     = 1'b0;
      in_ch.text_byte = 8'($urandom_range(0, 255));
      in_ch.is_final  = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_ch.text_byte = b;
    in_ch.is_final  = fin;
    in_ch.valid     = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends the bytes in text_q as one buffer, the last byte marked final.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    in_ch.valid = 1'b0;
  endtask

  // A byte for comment or literal bodies: often high, sometimes star or slash.
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(8'h80, 8'hFF));
      4:          return chbs_pkg::CH_STAR;
      5:          return chbs_pkg::CH_SLASH;
      default:    return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  // Appends one lexical fragment of random content to text_q.
  function automatic void add_fragment();
    int n;
    n = $urandom_range(0, 6);
    case ($urandom_range(0, 5))
      0: begin
        // Raw noise.
        repeat (n + 1) text_q.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        // Plain code.
        repeat (n + 1) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
      2: begin
        // Quoted literal with escapes and high bytes.
        logic [7:0] quote;
        quote = $urandom_range(0, 1) ? chbs_pkg::CH_DQUOTE : chbs_pkg::CH_SQUOTE;
        text_q.push_back(quote);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
            1: begin
              text_q.push_back(chbs_pkg::CH_BSLASH);
              text_q.push_back($urandom_range(0, 1) ? quote : 8'($urandom_range(0, 255)));
            end
            default: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
          endcase
        end
        text_q.push_back(quote);
      end
      3: begin
        // Line comment closed by CR or LF.
        text_q.push_back(chbs_pkg::CH_SLASH);
        text_q.push_back(chbs_pkg::CH_SLASH);
        repeat (n) text_q.push_back(body_byte());
        text_q.push_back($urandom_range(0, 1) ? chbs_pkg::CH_CR : chbs_pkg::CH_LF);
      end
      4: begin
        // Block comment, sometimes closed by a run of stars.
        text_q.push_back(chbs_pkg::CH_SLASH);
        text_q.push_back(chbs_pkg::CH_STAR);
        repeat (n) text_q.push_back(body_byte());
        repeat ($urandom_range(1, 3)) text_q.push_back(chbs_pkg::CH_STAR);
        text_q.push_back(chbs_pkg::CH_SLASH);
      end
      default: begin
        // A slash that opens no comment.
        text_q.push_back(chbs_pkg::CH_SLASH);
        case ($urandom_range(0, 2))
          0:       text_q.push_back(chbs_pkg::CH_DQUOTE);
          1:       text_q.push_back(chbs_pkg::CH_SQUOTE);
          default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    endcase
  endfunction

  // Sends random buffers until about nbytes bytes have gone in.
  task automatic send_random_text(input int nbytes);
    int sent;
    int cut;
    sent = 0;
    while (sent < nbytes) begin
      text_q.delete();
      repeat ($urandom_range(1, 6)) add_fragment();
      // Some buffers end in the middle of a construct.
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
      send_text();
      sent += text_q.size();
    end
  endtask

  initial begin
    sb              = new();
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = 8'h00;
    in_ch.is_final  = 1'b0;
    send_idle_pct   = 28;
    recv_idle_pct   = 46;
    hold_request    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Byte extremes in code, a line comment closed by CR, a block comment with
    // star runs and a high byte after a star, a string with an escaped quote
    // and a high byte, then a backslash that ends its buffer.
    text_q = '{8'h00, 8'hFF,
               chbs_pkg::CH_SLASH, chbs_pkg::CH_SLASH, 8'h80, chbs_pkg::CH_CR,
               chbs_pkg::CH_SLASH, chbs_pkg::CH_STAR, 8'h90, chbs_pkg::CH_STAR,
               chbs_pkg::CH_STAR, 8'hFF, chbs_pkg::CH_STAR, chbs_pkg::CH_SLASH,
               chbs_pkg::CH_DQUOTE, chbs_pkg::CH_BSLASH, chbs_pkg::CH_DQUOTE, 8'hA0,
               chbs_pkg::CH_DQUOTE,
               chbs_pkg::CH_SQUOTE, chbs_pkg::CH_BSLASH};
    send_text();
    // Slash at buffer end: the star after it opens nothing.
    text_q = '{chbs_pkg::CH_SLASH};
    send_text();
    // Star at buffer end inside a block comment: the next slash closes nothing.
    text_q = '{chbs_pkg::CH_STAR, chbs_pkg::CH_SLASH, chbs_pkg::CH_STAR, chbs_pkg::CH_STAR};
    send_text();
    text_q = '{chbs_pkg::CH_SLASH};
    send_text();

    // Sender idles less than the receiver; one long receiver hold-off.
    hold_request = 1'b1;
    send_random_text(PHASE_BYTES);

    send_idle_pct = 46;
    recv_idle_pct = 28;
    send_random_text(PHASE_BYTES);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_text(PHASE_BYTES);

    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/chbs_pkg.sv
sv/chbs_if.sv
sv/chbs_lex_step.sv
sv/comment_high_byte_scrubber_top.sv
tb/testbench.sv
